### rtl/core/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros used by the console writer checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS       = 80;
	localparam int DEF_ROWS          = 25;
	localparam int DEF_LINE_CAPACITY = 128;

	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int COL_OUT_W  = 7;
	localparam int ROW_OUT_W  = 5;
	localparam int POS_OUT_W  = 11;
	localparam int LEN_OUT_W  = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CHAR_W-1:0] NEWLINE_RESET   = 8'd10;
	localparam logic [CHAR_W-1:0] BACKSPACE_RESET = 8'd8;
	localparam logic [CHAR_W-1:0] LF_CODE         = 8'd10;

	typedef enum logic [1:0] {
		CMD_PUT,
		CMD_LINE_START,
		CMD_READ_CELL,
		CMD_READ_LINE
	} cmd_t;

	typedef enum logic [0:0] {
		REG_NEWLINE,
		REG_BACKSPACE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCROLL,
		S_BS_RD,
		S_BS_CHK,
		S_DONE
	} state_t;

endpackage

### rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character grid with cursor, scrolling and line capture.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  command, char_code, index
//  output    out        out_valid/out_stall  cursor_col, cursor_row, cursor_pos,
//                                            capturing, line_length, read_data
//  config    in         APB write/read       newline_code @0, backspace_code @4
//
//  Put and line start: accept, exec, done; in-range reads add a read state.
//  Scroll: one cell moved per cycle through the grid RAM.
//  Backspace at column 0: steps back over blank cells, one grid read per column.
//  After reset the grid RAM is cleared, one cell a cycle, with in_stall high.
//  One waiting result does not block the next request; a second finished
//  result waits in the done state with in_stall high.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS       = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS          = tcw_pkg::DEF_ROWS,
	parameter int LINE_CAPACITY = tcw_pkg::DEF_LINE_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      command,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]     index,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
	output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
	output logic [tcw_pkg::POS_OUT_W-1:0]   cursor_pos,
	output logic                            capturing,
	output logic [tcw_pkg::LEN_OUT_W-1:0]   line_length,
	output logic [tcw_pkg::CHAR_W-1:0]      read_data,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int PTR_END  = CELLS + COLUMNS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(COLUMNS);
	localparam int RW       = $clog2(ROWS);
	localparam int LAW      = $clog2(LINE_CAPACITY);
	localparam int LCW      = $clog2(LINE_CAPACITY + 1);
	localparam int PW       = $clog2(PTR_END + 1);
	localparam int LAST_POS = (ROWS - 1) * COLUMNS;
	localparam int CHW      = tcw_pkg::CHAR_W;

	tcw_pkg::state_t state_q, state_d;

	tcw_pkg::cmd_t       cmd_q;
	logic [CHW-1:0]      char_q;
	logic [tcw_pkg::INDEX_W-1:0] idx_q;
	logic [CHW-1:0]      data_q, data_d;

	logic [CW-1:0]       col_q, col_d;
	logic [RW-1:0]       row_q, row_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic [LCW-1:0]      count_q, count_d;
	logic                capture_q, capture_d;
	logic [CHW-1:0]      nl_code_q, bs_code_q;
	logic [PW-1:0]       ptr_q, ptr_d;

	logic                pend_s1, pend_d;
	logic                zero_s1, zero_d;
	logic [AW-1:0]       dest_s1, dest_d;

	logic                out_valid_q;
	logic                out_load;
	logic [tcw_pkg::COL_OUT_W-1:0] out_col_q;
	logic [tcw_pkg::ROW_OUT_W-1:0] out_row_q;
	logic [tcw_pkg::POS_OUT_W-1:0] out_pos_q;
	logic                out_cap_q;
	logic [tcw_pkg::LEN_OUT_W-1:0] out_len_q;
	logic [CHW-1:0]      out_data_q;

	logic                scr_we;
	logic [AW-1:0]       scr_waddr;
	logic [CHW-1:0]      scr_wdata;
	logic [AW-1:0]       scr_raddr;
	logic [CHW-1:0]      scr_rdata;
	logic                ln_we;
	logic [LAW-1:0]      ln_waddr;
	logic [CHW-1:0]      ln_wdata;
	logic [LAW-1:0]      ln_raddr;
	logic [CHW-1:0]      ln_rdata;

	logic                in_accept;
	logic                cfg_write;
	tcw_pkg::cfg_reg_t   cfg_sel;

	tcw_ram #(.WIDTH(CHW), .DEPTH(CELLS)) u_screen_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	tcw_ram #(.WIDTH(CHW), .DEPTH(LINE_CAPACITY)) u_line_ram (
		.clk   (clk),
		.we    (ln_we),
		.waddr (ln_waddr),
		.wdata (ln_wdata),
		.raddr (ln_raddr),
		.rdata (ln_rdata)
	);

	assign in_stall  = (state_q != tcw_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == tcw_pkg::S_DONE) && (!out_valid_q || !out_stall);

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_sel   = tcw_pkg::cfg_reg_t'(paddr[2]);

	always_comb begin
		prdata = '0;
		case (cfg_sel)
			tcw_pkg::REG_NEWLINE:   prdata[CHW-1:0] = nl_code_q;
			tcw_pkg::REG_BACKSPACE: prdata[CHW-1:0] = bs_code_q;
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		pos_d     = pos_q;
		count_d   = count_q;
		capture_d = capture_q;
		ptr_d     = ptr_q;
		data_d    = data_q;
		pend_d    = 1'b0;
		zero_d    = 1'b0;
		dest_d    = AW'(ptr_q - PW'(COLUMNS));
		scr_we    = 1'b0;
		scr_waddr = pos_q;
		scr_wdata = '0;
		scr_raddr = AW'(idx_q);
		ln_we     = 1'b0;
		ln_waddr  = count_q[LAW-1:0];
		ln_wdata  = char_q;
		ln_raddr  = LAW'(idx_q);

		// pipelined scroll write, in the cycle after its read
		if (pend_s1) begin
			scr_we    = 1'b1;
			scr_waddr = dest_s1;
			scr_wdata = zero_s1 ? '0 : scr_rdata;
		end

		case (state_q)
			tcw_pkg::S_CLEAR: begin
				scr_we    = 1'b1;
				scr_waddr = AW'(ptr_q);
				scr_wdata = '0;
				if (ptr_q == PW'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = tcw_pkg::S_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end

			tcw_pkg::S_IDLE: begin
				if (in_accept) begin
					data_d  = '0;
					state_d = tcw_pkg::S_EXEC;
				end
			end

			tcw_pkg::S_EXEC: begin
				state_d = tcw_pkg::S_DONE;
				case (cmd_q)
					tcw_pkg::CMD_LINE_START: begin
						capture_d = 1'b1;
						count_d   = '0;
					end
					tcw_pkg::CMD_READ_CELL: begin
						if (32'(idx_q) < CELLS) begin
							state_d = tcw_pkg::S_READ;
						end
					end
					tcw_pkg::CMD_READ_LINE: begin
						if (32'(idx_q) < 32'(count_q)) begin
							state_d = tcw_pkg::S_READ;
						end
					end
					tcw_pkg::CMD_PUT: begin
						if (char_q == nl_code_q) begin
							if (capture_q) begin
								capture_d = 1'b0;
								if (32'(count_q) < LINE_CAPACITY) begin
									ln_we    = 1'b1;
									ln_wdata = tcw_pkg::LF_CODE;
									count_d  = count_q + 1'b1;
								end
							end
							col_d = '0;
							if (row_q == RW'(ROWS - 1)) begin
								pos_d   = AW'(LAST_POS);
								ptr_d   = PW'(COLUMNS);
								state_d = tcw_pkg::S_SCROLL;
							end else begin
								row_d = row_q + 1'b1;
								pos_d = pos_q + AW'(COLUMNS) - AW'(col_q);
							end
						end else if (char_q == bs_code_q) begin
							if (!(capture_q && count_q == '0)) begin
								if (capture_q) begin
									count_d = count_q - 1'b1;
								end
								if (col_q == '0) begin
									if (row_q != '0) begin
										row_d     = row_q - 1'b1;
										col_d     = CW'(COLUMNS - 1);
										pos_d     = pos_q - 1'b1;
										scr_we    = 1'b1;
										scr_waddr = pos_q - 1'b1;
										state_d   = tcw_pkg::S_BS_RD;
									end
								end else begin
									col_d     = col_q - 1'b1;
									pos_d     = pos_q - 1'b1;
									scr_we    = 1'b1;
									scr_waddr = pos_q - 1'b1;
								end
							end
						end else begin
							if (capture_q && 32'(count_q) < LINE_CAPACITY - 1) begin
								ln_we   = 1'b1;
								count_d = count_q + 1'b1;
							end
							scr_we    = 1'b1;
							scr_waddr = pos_q;
							scr_wdata = char_q;
							if (col_q == CW'(COLUMNS - 1)) begin
								col_d = '0;
								if (row_q == RW'(ROWS - 1)) begin
									pos_d   = AW'(LAST_POS);
									ptr_d   = PW'(COLUMNS);
									state_d = tcw_pkg::S_SCROLL;
								end else begin
									row_d = row_q + 1'b1;
									pos_d = pos_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
								pos_d = pos_q + 1'b1;
							end
						end
					end
					default: state_d = tcw_pkg::S_DONE;
				endcase
			end

			tcw_pkg::S_READ: begin
				data_d  = (cmd_q == tcw_pkg::CMD_READ_LINE) ? ln_rdata : scr_rdata;
				state_d = tcw_pkg::S_DONE;
			end

			tcw_pkg::S_SCROLL: begin
				// read cell ptr, write it one row up next cycle; past the grid, write zeros
				if (ptr_q < PW'(PTR_END)) begin
					scr_raddr = AW'(ptr_q);
					pend_d    = 1'b1;
					zero_d    = (ptr_q >= PW'(CELLS));
					ptr_d     = ptr_q + 1'b1;
				end else begin
					ptr_d   = '0;
					state_d = tcw_pkg::S_DONE;
				end
			end

			tcw_pkg::S_BS_RD: begin
				if (col_q == '0) begin
					state_d = tcw_pkg::S_DONE;
				end else begin
					scr_raddr = pos_q - 1'b1;
					state_d   = tcw_pkg::S_BS_CHK;
				end
			end

			tcw_pkg::S_BS_CHK: begin
				if (scr_rdata == '0) begin
					col_d   = col_q - 1'b1;
					pos_d   = pos_q - 1'b1;
					state_d = tcw_pkg::S_BS_RD;
				end else begin
					state_d = tcw_pkg::S_DONE;
				end
			end

			tcw_pkg::S_DONE: begin
				if (out_load) begin
					state_d = tcw_pkg::S_IDLE;
				end
			end

			default: state_d = tcw_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			capture_q   <= 1'b0;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			nl_code_q   <= tcw_pkg::NEWLINE_RESET;
			bs_code_q   <= tcw_pkg::BACKSPACE_RESET;
		end else begin
			col_q       <= col_d;
			row_q       <= row_d;
			pos_q       <= pos_d;
			count_q     <= count_d;
			capture_q   <= capture_d;
			ptr_q       <= ptr_d;
			pend_s1     <= pend_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cfg_write) begin
				case (cfg_sel)
					tcw_pkg::REG_NEWLINE:   nl_code_q <= pwdata[CHW-1:0];
					tcw_pkg::REG_BACKSPACE: bs_code_q <= pwdata[CHW-1:0];
					default:                nl_code_q <= nl_code_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= tcw_pkg::cmd_t'(command);
			char_q <= char_code;
			idx_q  <= index;
		end
		data_q  <= data_d;
		zero_s1 <= zero_d;
		dest_s1 <= dest_d;
		if (out_load) begin
			out_col_q  <= tcw_pkg::COL_OUT_W'(col_q);
			out_row_q  <= tcw_pkg::ROW_OUT_W'(row_q);
			out_pos_q  <= tcw_pkg::POS_OUT_W'(pos_q);
			out_cap_q  <= capture_q;
			out_len_q  <= tcw_pkg::LEN_OUT_W'(count_q);
			out_data_q <= data_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_col  = out_col_q;
	assign cursor_row  = out_row_q;
	assign cursor_pos  = out_pos_q;
	assign capturing   = out_cap_q;
	assign line_length = out_len_q;
	assign read_data   = out_data_q;

endmodule

### rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker #(
	parameter int COLUMNS       = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS          = tcw_pkg::DEF_ROWS,
	parameter int LINE_CAPACITY = tcw_pkg::DEF_LINE_CAPACITY
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [tcw_pkg::COL_OUT_W-1:0] cursor_col,
	input logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
	input logic [tcw_pkg::POS_OUT_W-1:0] cursor_pos,
	input logic [tcw_pkg::LEN_OUT_W-1:0] line_length,
	input logic [tcw_pkg::CHAR_W-1:0]    read_data
);

	`TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_pos) && $stable(read_data) && $stable(line_length), "result changed while stalled")

	`TCW_ASSERT_NOW(a_col_range, out_valid, 32'(cursor_col) < COLUMNS, "cursor column out of range")

	`TCW_ASSERT_NOW(a_row_range, out_valid, 32'(cursor_row) < ROWS, "cursor row out of range")

	`TCW_ASSERT_NOW(a_len_range, out_valid, 32'(line_length) <= LINE_CAPACITY, "line length above capacity")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS       (COLUMNS),
	.ROWS          (ROWS),
	.LINE_CAPACITY (LINE_CAPACITY)
) u_tcw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.cursor_col  (cursor_col),
	.cursor_row  (cursor_row),
	.cursor_pos  (cursor_pos),
	.line_length (line_length),
	.read_data   (read_data)
);
